// ----- rtl/tce_pkg.sv -----
// Package for the text console engine: geometry, field widths, character codes
// and request kinds.
// No dependencies; imported by the core and by its checker.
`default_nettype none

package tce_pkg;

    localparam int COLS     = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;
    localparam int CELLS    = COLS * ROWS;

    localparam int ADDR_W = $clog2(CELLS);
    localparam int PA_W   = ADDR_W + 1;
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CX_W   = $clog2(COLS + TAB_STOP + 1);
    localparam int RX_W   = $clog2(ROWS + 1);

    localparam int REQ_W  = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd15;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUT   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

endpackage

`default_nettype wire

// ----- rtl/text_console_engine_core.sv -----
// Text console engine: teletype cursor logic over an 80x25 screen memory.
// Depends on tce_pkg.
//
// Usage. Requests arrive on the s_axis channel: tuser carries the request kind
// (put character, clear screen, read cell) and tdata the character code and
// the cell index. Each request yields exactly one result transfer on m_axis,
// carrying the cursor location after the request and, for reads, the cell.
// The attribute byte is written through cfg_we/cfg_data; the user is to
// write it only while the block idles; the block itself does not enforce this.
// Flow. One request is in work at a time; s_axis_tready is high only when
// the engine is idle, which it returns to only after loading the result into
// the output register. A put, an unused kind or an out-of-range read goes
// from the execute to the emit state, a read through a memory read state
// between them. Scrolling moves a row base pointer rather than the text, so a
// scroll blanks only the new bottom row (COLS, 80 cells); a clear blanks all
// CELLS (2000) cells. Both sweeps write through the single memory write port.
// Reset. After rst_n is released the engine blanks the whole memory with
// attribute 15 before it accepts the first request.
// Stalls. A result waits in the output register while m_axis_tready is low;
// the next request is still accepted and processed, and its result waits
// for the output register to free.
`default_nettype none

module text_console_engine_core
    import tce_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // s_axis_tdata: char_code [7:0], cell_index [18:8], zeros above.
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    // s_axis_tuser: req_type [1:0].
    input  wire logic [REQ_W-1:0]    s_axis_tuser,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // m_axis_tdata: cursor_pos [10:0], cell_data [26:11], zeros above.
    output logic [M_DATA_W-1:0]      m_axis_tdata,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    input  wire logic                cfg_we,
    input  wire logic [ATTR_W-1:0]   cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_READ  = 5'b00100,
        S_SWEEP = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    req_t                req_reg, req_next;
    logic [CHAR_W-1:0]   code_reg, code_next;
    logic [IDX_W-1:0]    cell_reg, cell_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [ADDR_W-1:0]   sweep_addr_reg, sweep_addr_next;
    logic [CNT_W-1:0]    sweep_left_reg, sweep_left_next;
    logic [ATTR_W-1:0]   sweep_attr_reg, sweep_attr_next;
    logic                sweep_emit_reg, sweep_emit_next;
    logic [ATTR_W-1:0]   attr_reg, attr_next;
    logic [CELL_W-1:0]   data_reg, data_next;
    logic                out_valid_reg, out_valid_next;
    logic [POS_W-1:0]    out_pos_reg, out_pos_next;
    logic [CELL_W-1:0]   out_data_reg, out_data_next;
    logic [CELL_W-1:0]   rd_data_reg;

    logic [CELL_W-1:0]   mem [CELLS];
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;

    logic [CX_W-1:0]     col_x;
    logic [RX_W-1:0]     row_x;
    logic                printable;
    logic [PA_W-1:0]     cur_lin;
    logic [PA_W-1:0]     cur_phys;
    logic [PA_W-1:0]     rd_phys;
    logic [PA_W-1:0]     base_step;
    logic                in_xfer;

    function automatic logic [PA_W-1:0] to_phys(input logic [PA_W-1:0] lin,
                                                input logic [ADDR_W-1:0] base);
        logic [PA_W-1:0] sum;
        sum = lin + PA_W'(base);
        if (sum >= PA_W'(CELLS))
        begin
            sum = sum - PA_W'(CELLS);
        end
        return sum;
    endfunction

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_DATA_W - POS_W - CELL_W){1'b0}}, out_data_reg, out_pos_reg};

    assign cur_lin   = PA_W'(PA_W'(row_reg) * PA_W'(COLS)) + PA_W'(col_reg);
    assign cur_phys  = to_phys(cur_lin, base_reg);
    assign rd_phys   = to_phys(PA_W'(cell_reg), base_reg);
    assign base_step = PA_W'(base_reg) + PA_W'(COLS);
    assign printable = (code_reg[CHAR_W-1] == 1'b0) && (code_reg >= CH_BLANK);

    always_comb
    begin
        col_x = CX_W'(col_reg);
        row_x = RX_W'(row_reg);
        case (code_reg)
            CH_BS:
            begin
                if (col_reg != '0)
                begin
                    col_x = CX_W'(col_reg) - CX_W'(1);
                end
            end
            CH_TAB:
            begin
                col_x = CX_W'(col_reg) + CX_W'(TAB_STOP)
                        - (CX_W'(col_reg) % CX_W'(TAB_STOP));
            end
            CH_CR:
            begin
                col_x = '0;
            end
            CH_LF:
            begin
                col_x = '0;
                row_x = RX_W'(row_reg) + RX_W'(1);
            end
            default:
            begin
                if (printable)
                begin
                    col_x = CX_W'(col_reg) + CX_W'(1);
                end
            end
        endcase
        if (col_x >= CX_W'(COLS))
        begin
            col_x = '0;
            row_x = row_x + RX_W'(1);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        code_next       = code_reg;
        cell_next       = cell_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        base_next       = base_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_left_next = sweep_left_reg;
        sweep_attr_next = sweep_attr_reg;
        sweep_emit_next = sweep_emit_reg;
        attr_next       = cfg_we ? cfg_data : attr_reg;
        data_next       = data_reg;
        out_valid_next  = out_valid_reg;
        out_pos_next    = out_pos_reg;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = cur_phys[ADDR_W-1:0];
        mem_wdata       = {attr_reg, code_reg};
        mem_re          = 1'b0;
        mem_raddr       = rd_phys[ADDR_W-1:0];

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    req_next   = req_t'(s_axis_tuser);
                    code_next  = s_axis_tdata[CHAR_W-1:0];
                    cell_next  = s_axis_tdata[CHAR_W +: IDX_W];
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                data_next  = '0;
                state_next = S_EMIT;
                case (req_reg)
                    REQ_PUT:
                    begin
                        mem_we   = printable;
                        col_next = COL_W'(col_x);
                        if (row_x >= RX_W'(ROWS))
                        begin
                            row_next        = ROW_W'(ROWS - 1);
                            sweep_addr_next = base_reg;
                            sweep_left_next = CNT_W'(COLS);
                            sweep_attr_next = attr_reg;
                            sweep_emit_next = 1'b1;
                            state_next      = S_SWEEP;
                            if (base_step >= PA_W'(CELLS))
                            begin
                                base_next = '0;
                            end
                            else
                            begin
                                base_next = base_step[ADDR_W-1:0];
                            end
                        end
                        else
                        begin
                            row_next = ROW_W'(row_x);
                        end
                    end
                    REQ_CLEAR:
                    begin
                        col_next        = '0;
                        row_next        = '0;
                        base_next       = '0;
                        sweep_addr_next = '0;
                        sweep_left_next = CNT_W'(CELLS);
                        sweep_attr_next = attr_reg;
                        sweep_emit_next = 1'b1;
                        state_next      = S_SWEEP;
                    end
                    REQ_READ:
                    begin
                        if ({1'b0, cell_reg} < (IDX_W + 1)'(CELLS))
                        begin
                            mem_re     = 1'b1;
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_READ:
            begin
                data_next  = rd_data_reg;
                state_next = S_EMIT;
            end
            S_SWEEP:
            begin
                mem_we          = 1'b1;
                mem_waddr       = sweep_addr_reg;
                mem_wdata       = {sweep_attr_reg, CH_BLANK};
                sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
                sweep_left_next = sweep_left_reg - CNT_W'(1);
                if (sweep_left_reg == CNT_W'(1))
                begin
                    state_next = sweep_emit_reg ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = POS_W'(cur_lin);
                    out_data_next  = data_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            col_reg        <= '0;
            row_reg        <= '0;
            base_reg       <= '0;
            sweep_addr_reg <= '0;
            sweep_left_reg <= CNT_W'(CELLS);
            sweep_attr_reg <= RESET_ATTR;
            sweep_emit_reg <= 1'b0;
            attr_reg       <= RESET_ATTR;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            base_reg       <= base_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_left_reg <= sweep_left_next;
            sweep_attr_reg <= sweep_attr_next;
            sweep_emit_reg <= sweep_emit_next;
            attr_reg       <= attr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        code_reg     <= code_next;
        cell_reg     <= cell_next;
        data_reg     <= data_next;
        out_pos_reg  <= out_pos_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// ----- rtl/tce_checker.sv -----
// Port-level checker for the text console engine core, with its bind statement.
// Depends on tce_pkg and attaches to text_console_engine_core.
`default_nettype none

module tce_checker
    import tce_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic [M_DATA_W-1:0] m_axis_tdata,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result withdrawn before its transfer");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while another is in work");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[POS_W-1:0] < POS_W'(CELLS)))
        else $error("cursor location beyond the screen");

    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while the engine was idle");

endmodule

bind text_console_engine_core tce_checker u_tce_checker (.*);

`default_nettype wire

// ----- test/tce_console_checker.sv -----
// Checker for the text console engine: it follows the request, result and attribute
// transfers, keeps its own copy of the screen and cursor, and compares every result.
// Depends on tce_pkg; instantiated beside the core by text_console_engine_core_tb.

module tce_console_checker
    import tce_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    input  logic [REQ_W-1:0]    s_axis_tuser,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [M_DATA_W-1:0] m_axis_tdata,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic                cfg_we,
    input  logic [ATTR_W-1:0]   cfg_data,
    output int                  mismatches,
    output int                  outstanding,
    output int                  results_checked,
    output int                  scrolls
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CHAR_W-1:0] CH_LAST_PRINT = 8'h7F;

    typedef struct packed {
        logic [POS_W-1:0]  cursor;
        logic [CELL_W-1:0] data;
    } console_result_t;

    logic [CELL_W-1:0] screen [CELLS];
    logic [CX_W-1:0]   col;
    logic [RX_W-1:0]   row;
    logic [ATTR_W-1:0] attr;
    console_result_t   expected_q [$];

    task automatic blank_rows(input int first);
        for (int i = first; i < CELLS; i++)
            screen[i] = {attr, CH_BLANK};
    endtask

    task automatic scroll_up();
        for (int i = 0; i < (ROWS - 1) * COLS; i++)
            screen[i] = screen[i + COLS];
        blank_rows((ROWS - 1) * COLS);
        row = RX_W'(ROWS - 1);
        scrolls++;
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] code);
        int at;
        if (code == CH_BS)
        begin
            if (col != 0)
                col = col - 1'b1;
        end
        else if (code == CH_TAB)
            col = CX_W'(col + TAB_STOP - (col % TAB_STOP));
        else if (code == CH_CR)
            col = '0;
        else if (code == CH_LF)
        begin
            col = '0;
            row = row + 1'b1;
        end
        else if (code >= CH_BLANK && code <= CH_LAST_PRINT)
        begin
            at = row * COLS + col;
            if (at < CELLS)
                screen[at] = {attr, code};
            col = col + 1'b1;
        end
        if (col >= COLS)
        begin
            col = '0;
            row = row + 1'b1;
        end
        if (row >= ROWS)
            scroll_up();
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        console_result_t   want;
        logic [POS_W-1:0]  got_pos;
        logic [CELL_W-1:0] got_cell;
        logic [IDX_W-1:0]  idx;
        logic [CELL_W-1:0] rd_cell;
        if (!rst_n)
        begin
            attr = RESET_ATTR;
            col = '0;
            row = '0;
            blank_rows(0);
            expected_q.delete();
            mismatches = 0;
            results_checked = 0;
            scrolls = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_pos  = m_axis_tdata[POS_W-1:0];
                got_cell = m_axis_tdata[POS_W +: CELL_W];
                if (expected_q.size() == 0)
                begin
                    $error("Result transfer with none expected: cursor_pos %0d, cell_data 0x%04h",
                           got_pos, got_cell);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    results_checked++;
                    if (got_pos !== want.cursor)
                    begin
                        $error("cursor_pos mismatch: expected %0d, got %0d", want.cursor, got_pos);
                        mismatches++;
                    end
                    if (got_cell !== want.data)
                    begin
                        $error("cell_data mismatch: expected 0x%04h, got 0x%04h",
                               want.data, got_cell);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
                attr = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                idx     = s_axis_tdata[CHAR_W +: IDX_W];
                rd_cell = '0;
                case (req_t'(s_axis_tuser))
                    REQ_PUT:
                        put_char(s_axis_tdata[CHAR_W-1:0]);
                    REQ_CLEAR:
                    begin
                        blank_rows(0);
                        col = '0;
                        row = '0;
                    end
                    REQ_READ:
                        if (idx < CELLS)
                            rd_cell = screen[idx];
                    default:
                        ;
                endcase
                want.cursor = POS_W'(row * COLS + col);
                want.data   = rd_cell;
                expected_q.push_back(want);
            end
        end
        outstanding = expected_q.size();
    end

endmodule

// ----- test/text_console_engine_core_tb.sv -----
// Top-level testbench for text_console_engine_core: clock, reset, request and
// attribute stimulus, result back-pressure and the final verdict.
// Depends on tce_pkg, text_console_engine_core and tce_console_checker.

module text_console_engine_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tce_pkg::*;

    localparam int  PHASE_ITEMS = 200;
    localparam int  PAUSE       = CELLS + 100;
    localparam int  HOLD_AT     = 300;
    localparam int  HOLD_CYCLES = 600;
    localparam logic [CHAR_W-1:0] CH_LAST_PRINT = 8'h7F;

    logic                clk = 1'b0;
    logic                rst_n;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic [REQ_W-1:0]    s_axis_tuser;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic                cfg_we;
    logic [ATTR_W-1:0]   cfg_data;

    int mismatches;
    int outstanding;
    int results_checked;
    int scrolls;
    int items_sent;
    int clears_sent;
    int reads_sent;

    text_console_engine_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data)
    );

    tce_console_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .scrolls         (scrolls)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #32_000_000;
        $display("FAIL text_console_engine_core");
        $finish;
    end

    // Result sink: random stalls, calm stretches, and one long hold to back the block up.
    initial
    begin : sink
        int taken;
        int hold;
        taken = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (taken == HOLD_AT)
                hold = HOLD_CYCLES;
            else if (taken % 70 < 15)
                hold = 0;
            else
                hold = $urandom_range(0, 8);
            if (hold != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            taken++;
            @(negedge clk);
        end
    end

    task automatic send(input req_t kind, input logic [CHAR_W-1:0] code,
                        input logic [IDX_W-1:0] idx);
        int gap;
        gap = (items_sent % 80 < 20) ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= S_DATA_W'({idx, code});
        s_axis_tuser  <= kind;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
        if (kind == REQ_CLEAR)
            clears_sent++;
        if (kind == REQ_READ)
            reads_sent++;
    endtask

    task automatic put(input logic [CHAR_W-1:0] code);
        send(REQ_PUT, code, IDX_W'($urandom_range(0, 2047)));
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        wait (outstanding == 0);
        repeat (PAUSE) @(negedge clk);
    endtask

    task automatic write_attr(input logic [ATTR_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Mostly lines of text and line feeds, with read bursts, clears and raw noise mixed in.
    task automatic random_traffic(input int count);
        int stop;
        int pick;
        int n;
        int r;
        stop = items_sent + count;
        while (items_sent < stop)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 20) : $urandom_range(60, 100);
                repeat (n)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 92)
                        put(CHAR_W'($urandom_range(CH_BLANK, CH_LAST_PRINT)));
                    else if (r < 96)
                        put(CH_TAB);
                    else
                        put(CH_BS);
                end
                r = $urandom_range(0, 99);
                if (r < 60)
                    put(CH_LF);
                else if (r < 80)
                begin
                    put(CH_CR);
                    put(CH_LF);
                end
            end
            else if (pick < 55)
            begin
                repeat ($urandom_range(1, 30))
                    put(($urandom_range(0, 9) == 0) ? CH_CR : CH_LF);
            end
            else if (pick < 77)
            begin
                repeat ($urandom_range(1, 8))
                begin
                    r = $urandom_range(0, 9);
                    if (r < 5)
                        n = $urandom_range(0, CELLS - 1);
                    else if (r < 8)
                        n = $urandom_range(CELLS - 2 * COLS, CELLS - 1);
                    else if (r < 9)
                        n = $urandom_range(0, COLS - 1);
                    else
                        n = $urandom_range(0, 2047);
                    send(REQ_READ, CHAR_W'($urandom_range(0, 255)), IDX_W'(n));
                end
            end
            else if (pick < 80)
                send(REQ_CLEAR, CHAR_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 2047)));
            else
                send(req_t'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                     IDX_W'($urandom_range(0, 2047)));
        end
    endtask

    initial
    begin : stimulus
        logic [ATTR_W-1:0] attr_plan [6];
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_PUT;
        s_axis_tvalid = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        items_sent    = 0;
        clears_sent   = 0;
        reads_sent    = 0;
        attr_plan = '{8'h00, 8'hFF, ATTR_W'($urandom_range(0, 255)), 8'h80,
                      ATTR_W'($urandom_range(0, 255)), 8'h01};
        @(posedge rst_n);
        @(negedge clk);

        send(REQ_READ, 8'h00, 11'd0);
        send(REQ_PUT, CH_BS, 11'd0);
        send(REQ_PUT, CH_BLANK, 11'h7FF);
        send(REQ_PUT, CH_LAST_PRINT, 11'd0);
        send(REQ_PUT, 8'h41, 11'd0);
        send(REQ_PUT, CH_BS, 11'd0);
        send(REQ_PUT, CH_TAB, 11'd0);
        send(REQ_PUT, CH_TAB, 11'd0);
        send(REQ_PUT, 8'h80, 11'd0);
        send(REQ_PUT, 8'hFF, 11'd0);
        send(REQ_PUT, 8'h00, 11'd0);
        send(REQ_PUT, 8'h1F, 11'd0);
        send(REQ_PUT, CH_CR, 11'd0);
        send(REQ_PUT, CH_LF, 11'd0);
        send(REQ_READ, 8'hFF, 11'd1);
        send(REQ_READ, 8'h00, IDX_W'(CELLS - 1));
        send(REQ_READ, 8'h00, IDX_W'(CELLS));
        send(REQ_READ, 8'h00, 11'h7FF);
        send(REQ_NONE, 8'hFF, 11'h7FF);
        send(REQ_CLEAR, 8'h41, 11'd0);
        send(REQ_READ, 8'h00, 11'd2);
        settle();

        foreach (attr_plan[i])
        begin
            write_attr(attr_plan[i]);
            random_traffic(PHASE_ITEMS);
            settle();
        end

        if (outstanding != 0)
            $error("%0d expected results never arrived", outstanding);
        $display("Sent %0d requests (%0d reads, %0d clears) over seven attribute settings.",
                 items_sent, reads_sent, clears_sent);
        $display("Checked %0d results; the screen scrolled %0d times.", results_checked, scrolls);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS text_console_engine_core");
        else
            $display("FAIL text_console_engine_core");
        $finish;
    end

endmodule
